/* src/etc1d_pkg.sv */
// Package for the ETC1 block decoder.
// Holds the stage payload structs, the modifier table and the index remap.
// Has no dependencies. All other files use it by scoped names.
package etc1d_pkg;

    localparam int CH_N  = 3;
    localparam int MOD_W = 9;

    // Pixel counter value of the sixteenth pixel of a block.
    localparam logic [3:0] PIX_LAST = 4'hF;

    typedef logic signed [MOD_W-1:0] modifier_t;

    // A decoded block as held while its pixels are issued.
    typedef struct packed {
        logic [CH_N-1:0][7:0] base1;
        logic [CH_N-1:0][7:0] base2;
        logic [2:0]           code1;
        logic [2:0]           code2;
        logic                 flip;
        logic [15:0]          msb_plane;
        logic [15:0]          lsb_plane;
    } block_t;

    // One pixel with its subblock base and modifier chosen.
    typedef struct packed {
        logic [1:0]           row;
        logic [1:0]           col;
        logic [CH_N-1:0][7:0] base;
        modifier_t            modifier;
        logic                 last;
    } texel_t;

    // One pixel with its channels clamped.
    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } colour_t;

    localparam modifier_t MOD_TAB [8][4] = '{
        '{-9'sd8,   -9'sd2,  9'sd2,  9'sd8},
        '{-9'sd17,  -9'sd5,  9'sd5,  9'sd17},
        '{-9'sd29,  -9'sd9,  9'sd9,  9'sd29},
        '{-9'sd42,  -9'sd13, 9'sd13, 9'sd42},
        '{-9'sd60,  -9'sd18, 9'sd18, 9'sd60},
        '{-9'sd80,  -9'sd24, 9'sd24, 9'sd80},
        '{-9'sd106, -9'sd33, 9'sd33, 9'sd106},
        '{-9'sd183, -9'sd47, 9'sd47, 9'sd183}
    };

    // The stored two-bit index does not run in table order.
    function automatic logic [1:0] remap_index(input logic [1:0] sel);
        logic [1:0] t;
        case (sel)
            2'd0:    t = 2'd2;
            2'd1:    t = 2'd3;
            2'd2:    t = 2'd1;
            default: t = 2'd0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

/* src/etc1_block_decoder_core.sv */
// Top level of the ETC1 block decoder.
// Connects the block sequencer, the select stage and the shading stages.
// Depends on etc1d_pkg, etc1d_unpack, etc1d_select and etc1d_shade.
//
// Usage: one 64-bit ETC1 block enters on the block channel as header_word
// and index_word with block_valid; a transfer happens at a rising edge where
// block_valid is high and block_stall is low. The block's sixteen pixels
// leave on the pixel channel in row-major order, each with its row, column,
// RGB888 channels, RGB565 word and last_pixel set on the sixteenth.
// The first pixel of a block passes the select, clamp and output registers.
// Throughput: one pixel per cycle while pixel_stall is low; the block
// register issues one pixel slot a cycle and takes the next block on
// the same edge that its sixteenth pixel moves on.
// Reset clears every valid bit and the pixel counter; no block is held.
// When the receiver raises pixel_stall the output pixel holds, the stages
// behind it fill up and block_stall stays high; nothing is lost or repeated.
module etc1_block_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        block_valid,
    output logic        block_stall,
    input  logic [31:0] header_word,
    input  logic [31:0] index_word,
    output logic        pixel_valid,
    input  logic        pixel_stall,
    output logic [1:0]  pixel_row,
    output logic [1:0]  pixel_col,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [15:0] rgb565,
    output logic        last_pixel
);

    logic              blk_valid;
    etc1d_pkg::block_t blk;
    logic [3:0]        pix_cnt;
    logic              sel_ready;
    logic              tex_valid;
    etc1d_pkg::texel_t tex;
    logic              shade_ready;

    etc1d_unpack u_unpack (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_valid (block_valid),
        .block_stall (block_stall),
        .header_word (header_word),
        .index_word  (index_word),
        .blk_valid   (blk_valid),
        .blk         (blk),
        .pix_cnt     (pix_cnt),
        .next_ready  (sel_ready)
    );

    etc1d_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_valid  (blk_valid),
        .blk        (blk),
        .pix_cnt    (pix_cnt),
        .this_ready (sel_ready),
        .tex_valid  (tex_valid),
        .tex        (tex),
        .next_ready (shade_ready)
    );

    etc1d_shade u_shade (
        .clk         (clk),
        .rst_n       (rst_n),
        .tex_valid   (tex_valid),
        .tex         (tex),
        .this_ready  (shade_ready),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .rgb565      (rgb565),
        .last_pixel  (last_pixel)
    );

endmodule

/* src/etc1d_unpack.sv */
// Block register and pixel sequencer of the ETC1 block decoder.
// Decodes the base colours on entry and issues sixteen pixel slots.
// Depends on etc1d_pkg.
module etc1d_unpack (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              block_valid,
    output logic              block_stall,
    input  logic [31:0]       header_word,
    input  logic [31:0]       index_word,
    output logic              blk_valid,
    output etc1d_pkg::block_t blk,
    output logic [3:0]        pix_cnt,
    input  logic              next_ready
);

    logic              blk_valid_reg, blk_valid_next;
    logic [3:0]        cnt_reg, cnt_next;
    etc1d_pkg::block_t blk_reg, blk_next;
    logic              advance, done, accept;
    logic [7:0]        byte_v;
    logic [4:0]        c5, sum5;
    logic [2:0]        d3;

    assign advance     = blk_valid_reg && next_ready;
    assign done        = advance && (cnt_reg == etc1d_pkg::PIX_LAST);
    assign block_stall = blk_valid_reg && !done;
    assign accept      = block_valid && !block_stall;

    always_comb
    begin
        blk_next           = blk_reg;
        blk_next.code1     = header_word[7:5];
        blk_next.code2     = header_word[4:2];
        blk_next.flip      = header_word[0];
        blk_next.msb_plane = index_word[31:16];
        blk_next.lsb_plane = index_word[15:0];
        byte_v = 8'h00;
        c5     = 5'd0;
        d3     = 3'd0;
        sum5   = 5'd0;
        for (int ch = 0; ch < etc1d_pkg::CH_N; ch++)
        begin
            byte_v = header_word[31 - 8*ch -: 8];
            c5     = byte_v[7:3];
            d3     = byte_v[2:0];
            // The delta is signed and the sum wraps within five bits.
            sum5   = c5 + {{2{d3[2]}}, d3};
            if (header_word[1])
            begin
                blk_next.base1[ch] = etc1d_pkg::expand5(c5);
                blk_next.base2[ch] = etc1d_pkg::expand5(sum5);
            end
            else
            begin
                blk_next.base1[ch] = {byte_v[7:4], byte_v[7:4]};
                blk_next.base2[ch] = {byte_v[3:0], byte_v[3:0]};
            end
        end
    end

    always_comb
    begin
        blk_valid_next = blk_valid_reg;
        if (accept)
            blk_valid_next = 1'b1;
        else if (done)
            blk_valid_next = 1'b0;
        cnt_next = advance ? cnt_reg + 4'd1 : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            blk_reg <= blk_next;
    end

    assign blk_valid = blk_valid_reg;
    assign blk       = blk_reg;
    assign pix_cnt   = cnt_reg;

    // A new block only enters once the previous one has issued all its pixels.
    a_accept_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!blk_valid_reg || done))
        else $error("block accepted while pixels remain");

    // Every accepted block starts from the first pixel.
    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (cnt_reg == 4'd0))
        else $error("block does not start at pixel zero");

endmodule

/* src/etc1d_select.sv */
// Pixel select stage of the ETC1 block decoder.
// Picks the subblock base and the modifier of one pixel and registers them.
// Depends on etc1d_pkg.
module etc1d_select (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              blk_valid,
    input  etc1d_pkg::block_t blk,
    input  logic [3:0]        pix_cnt,
    output logic              this_ready,
    output logic              tex_valid,
    output etc1d_pkg::texel_t tex,
    input  logic              next_ready
);

    logic              tex_valid_reg, tex_valid_next;
    etc1d_pkg::texel_t tex_reg, tex_next;
    logic [1:0]        row, col, sel, t;
    logic [3:0]        bit_idx;
    logic              first;

    assign this_ready = !tex_valid_reg || next_ready;

    always_comb
    begin
        row     = pix_cnt[3:2];
        col     = pix_cnt[1:0];
        // Index planes run column by column.
        bit_idx = {col, row};
        sel     = {blk.msb_plane[bit_idx], blk.lsb_plane[bit_idx]};
        t       = etc1d_pkg::remap_index(sel);
        first   = blk.flip ? !row[1] : !col[1];
        tex_next.row      = row;
        tex_next.col      = col;
        tex_next.base     = first ? blk.base1 : blk.base2;
        tex_next.modifier = etc1d_pkg::MOD_TAB[first ? blk.code1 : blk.code2][t];
        tex_next.last     = (pix_cnt == etc1d_pkg::PIX_LAST);
    end

    always_comb
    begin
        tex_valid_next = tex_valid_reg;
        if (this_ready)
            tex_valid_next = blk_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tex_valid_reg <= 1'b0;
        else
            tex_valid_reg <= tex_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (this_ready && blk_valid)
            tex_reg <= tex_next;
    end

    assign tex_valid = tex_valid_reg;
    assign tex       = tex_reg;

    // A held pixel is not overwritten while the next stage is full.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (tex_valid_reg && !next_ready) |=> (tex_valid_reg && $stable(tex_reg)))
        else $error("held pixel lost in select stage");

endmodule

/* src/etc1d_shade.sv */
// Shading stages of the ETC1 block decoder.
// Adds the modifier with clamping, then packs RGB565 into the output register.
// Depends on etc1d_pkg.
module etc1d_shade (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tex_valid,
    input  etc1d_pkg::texel_t tex,
    output logic              this_ready,
    output logic              pixel_valid,
    input  logic              pixel_stall,
    output logic [1:0]        pixel_row,
    output logic [1:0]        pixel_col,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [15:0]       rgb565,
    output logic              last_pixel
);

    logic               c_valid_reg, c_valid_next;
    etc1d_pkg::colour_t c_reg, c_next;
    logic               o_valid_reg, o_valid_next;
    etc1d_pkg::colour_t o_reg;
    logic [15:0]        o565_reg;
    logic               out_ready;
    logic [2:0][7:0]    chan;
    logic signed [9:0]  sum;

    assign out_ready  = !o_valid_reg || !pixel_stall;
    assign this_ready = !c_valid_reg || out_ready;

    always_comb
    begin
        chan = '0;
        sum  = '0;
        for (int ch = 0; ch < etc1d_pkg::CH_N; ch++)
        begin
            sum = signed'({2'b00, tex.base[ch]}) + {tex.modifier[8], tex.modifier};
            // The sum stays within -183..438, so bit 9 marks an underflow and bit 8 then marks an overflow.
            if (sum[9])
                chan[ch] = 8'h00;
            else if (sum[8])
                chan[ch] = 8'hFF;
            else
                chan[ch] = sum[7:0];
        end
        c_next.row   = tex.row;
        c_next.col   = tex.col;
        c_next.red   = chan[0];
        c_next.green = chan[1];
        c_next.blue  = chan[2];
        c_next.last  = tex.last;
    end

    always_comb
    begin
        c_valid_next = c_valid_reg;
        if (this_ready)
            c_valid_next = tex_valid;
        o_valid_next = o_valid_reg;
        if (out_ready)
            o_valid_next = c_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (this_ready && tex_valid)
            c_reg <= c_next;
        if (out_ready && c_valid_reg)
        begin
            o_reg    <= c_reg;
            o565_reg <= {c_reg.red[7:3], c_reg.green[7:2], c_reg.blue[7:3]};
        end
    end

    assign pixel_valid = o_valid_reg;
    assign pixel_row   = o_reg.row;
    assign pixel_col   = o_reg.col;
    assign red         = o_reg.red;
    assign green       = o_reg.green;
    assign blue        = o_reg.blue;
    assign rgb565      = o565_reg;
    assign last_pixel  = o_reg.last;

    // A clamped pixel waiting behind a stalled output is kept.
    a_clamp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !out_ready) |=> (c_valid_reg && $stable(c_reg)))
        else $error("clamped pixel lost behind stalled output");

    // The packed word always matches the channels shown beside it.
    a_pack: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (rgb565 == {red[7:3], green[7:2], blue[7:3]}))
        else $error("rgb565 does not match channels");

endmodule
